// ----- sv/mlr_pkg.sv -----
// Shared types, field layout and defaults for the midpoint line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

  // Default frame geometry and pixel depth
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 128;
  localparam int unsigned COLOR_BITS_DEF   = 8;

  // Fixed field widths
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PEN_W      = 8;
  localparam int unsigned RD_IDX_W   = 7;
  localparam int unsigned RES_COL_W  = 8;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Input tdata layout, lowest field first
  localparam int unsigned IN_SX_LSB   = 0;
  localparam int unsigned IN_SY_LSB   = IN_SX_LSB + COORD_W;
  localparam int unsigned IN_EX_LSB   = IN_SY_LSB + COORD_W;
  localparam int unsigned IN_EY_LSB   = IN_EX_LSB + COORD_W;
  localparam int unsigned IN_PEN_LSB  = IN_EY_LSB + COORD_W;
  localparam int unsigned IN_RCOL_LSB = IN_PEN_LSB + PEN_W;
  localparam int unsigned IN_RROW_LSB = IN_RCOL_LSB + RD_IDX_W;
  localparam int unsigned IN_USED_W   = IN_RROW_LSB + RD_IDX_W;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout
  localparam int unsigned OUT_COL_LSB  = 0;
  localparam int unsigned OUT_CNT_LSB  = OUT_COL_LSB + RES_COL_W;
  localparam int unsigned OUT_USED_W   = OUT_CNT_LSB + COUNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes carried in tuser
  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y_MIN = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_START,
    ST_DRAW,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  // One pixel of the line walk, walker to plot logic
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pixel_t;

endpackage

`default_nettype wire

// ----- sv/mlr_frame_mem.sv -----
// Frame store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mlr_frame_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/mlr_walker.sv -----
// Midpoint line walker: one pixel per cycle along the major axis.
`timescale 1ns / 1ps
`default_nettype none

module mlr_walker
  import mlr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [COORD_W-1:0] sx,
  input  wire logic signed [COORD_W-1:0] sy,
  input  wire logic signed [COORD_W-1:0] ex,
  input  wire logic signed [COORD_W-1:0] ey,
  output pixel_t                         pix
);

  // setup terms
  logic signed [COORD_W:0]   dx, dy;
  logic        [COORD_W-1:0] adx, ady, maj, mnr;
  logic                      steep, neg, flip;
  logic signed [ERR_W-1:0]   err0;

  // walk state
  logic                      active_r, active_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt;
  logic signed [COORD_W-1:0] y_r, y_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic        [COORD_W-1:0] rem_r, rem_nxt;
  logic                      steep_r, steep_nxt;
  logic                      neg_r, neg_nxt;
  logic        [COORD_W:0]   two_maj_r, two_maj_nxt;
  logic        [COORD_W:0]   two_mnr_r, two_mnr_nxt;
  logic                      step_minor;

  always_comb begin
    dx    = {ex[COORD_W-1], ex} - {sx[COORD_W-1], sx};
    dy    = {ey[COORD_W-1], ey} - {sy[COORD_W-1], sy};
    adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    // vertical and degenerate lines walk as steep lines
    steep = (dx == '0) || (ady > adx);
    neg   = (dy != '0) && (dx[COORD_W] != dy[COORD_W]);
    flip  = steep ? dy[COORD_W] : dx[COORD_W];
    maj   = steep ? ady : adx;
    mnr   = steep ? adx : ady;
    err0  = $signed({3'b000, mnr, 1'b0}) - $signed({4'b0000, maj});
  end

  assign step_minor = !err_r[ERR_W-1];

  always_comb begin
    active_nxt  = active_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    err_nxt     = err_r;
    rem_nxt     = rem_r;
    steep_nxt   = steep_r;
    neg_nxt     = neg_r;
    two_maj_nxt = two_maj_r;
    two_mnr_nxt = two_mnr_r;
    if (start) begin
      active_nxt  = 1'b1;
      x_nxt       = flip ? ex : sx;
      y_nxt       = flip ? ey : sy;
      err_nxt     = err0;
      rem_nxt     = maj;
      steep_nxt   = steep;
      neg_nxt     = neg;
      two_maj_nxt = {maj, 1'b0};
      two_mnr_nxt = {mnr, 1'b0};
    end else if (active_r) begin
      err_nxt = err_r + $signed({3'b000, two_mnr_r})
              - (step_minor ? $signed({3'b000, two_maj_r}) : ERR_W'(0));
      if (steep_r) begin
        y_nxt = y_r + 1'b1;
        if (step_minor) begin
          x_nxt = neg_r ? x_r - 1'b1 : x_r + 1'b1;
        end
      end else begin
        x_nxt = x_r + 1'b1;
        if (step_minor) begin
          y_nxt = neg_r ? y_r - 1'b1 : y_r + 1'b1;
        end
      end
      rem_nxt = rem_r - 1'b1;
      if (rem_r == '0) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    err_r     <= err_nxt;
    rem_r     <= rem_nxt;
    steep_r   <= steep_nxt;
    neg_r     <= neg_nxt;
    two_maj_r <= two_maj_nxt;
    two_mnr_r <= two_mnr_nxt;
  end

  always_comb begin
    pix.valid = active_r;
    pix.last  = (rem_r == '0);
    pix.x     = x_r;
    pix.y     = y_r;
  end

endmodule

`default_nettype wire

// ----- sv/mlr_clip.sv -----
// Viewport clip and frame address for one walked pixel (rows flipped).
`timescale 1ns / 1ps
`default_nettype none

module mlr_clip
  import mlr_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int unsigned AW           = 14
) (
  input  wire pixel_t                    pix,
  input  wire logic signed [COORD_W-1:0] view_x_min,
  input  wire logic signed [COORD_W-1:0] view_y_min,
  output logic                           hit,
  output logic [AW-1:0]                  addr
);

  localparam int unsigned RW = COORD_W + 2;
  localparam logic signed [RW-1:0] W_S    = RW'(FRAME_WIDTH);
  localparam logic signed [RW-1:0] H_S    = RW'(FRAME_HEIGHT);
  localparam logic signed [RW-1:0] HM1_S  = RW'(FRAME_HEIGHT - 1);
  localparam logic        [AW-1:0] W_A    = AW'(FRAME_WIDTH);

  logic signed [RW-1:0] col, rel, row;

  always_comb begin
    col  = RW'(pix.x) - RW'(view_x_min);
    rel  = RW'(pix.y) - RW'(view_y_min);
    row  = HM1_S - rel;
    hit  = pix.valid && !col[RW-1] && (col < W_S) && !rel[RW-1] && (rel < H_S);
    addr = AW'(AW'(row) * W_A) + AW'(col);
  end

endmodule

`default_nettype wire

// ----- sv/midpoint_line_rasterizer.sv -----
// Top level: midpoint line rasterizer with on-chip frame store.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a draw runs ST_DRAW_START, ST_DRAW for its N pixels, then ST_FINISH, N the
//   major-axis length plus one (N = max(|dx|,|dy|) + 1); a read runs ST_RD_ADDR, then
//   ST_RD_DATA and ST_FINISH. Throughput: one transaction at a time; the walker writes
//   one pixel per cycle into the single write port of the frame store, and ST_FINISH
//   holds while a previous result still waits in the output register.
// Reset (synchronous, rst_n low): after release a clearing pass writes zero to all
//   FRAME_WIDTH*FRAME_HEIGHT entries with in_tready low.

module midpoint_line_rasterizer
  import mlr_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int unsigned COLOR_BITS   = COLOR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
  //        pen_color[55:48], read_column[62:56], read_row[69:63], zero pad [71:70]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: operation[0] (0 draw, 1 read)
  input  wire logic [0:0]             in_tuser,
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: read_color[7:0], pixels_written[20:8], zero pad [23:21]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] W_A       = AW'(FRAME_WIDTH);
  localparam int unsigned   CMP_W     = COORD_W + 1;
  localparam logic [CMP_W-1:0] W_C    = CMP_W'(FRAME_WIDTH);
  localparam logic [CMP_W-1:0] H_C    = CMP_W'(FRAME_HEIGHT);

  // ---------------------------------------------------------------------
  // Viewport registers
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] view_x_min_r, view_y_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_min_r <= '0;
      view_y_min_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_X_MIN: view_x_min_r <= cfg_wdata[COORD_W-1:0];
        CFG_VIEW_Y_MIN: view_y_min_r <= cfg_wdata[COORD_W-1:0];
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Transaction fields, captured at acceptance
  // ---------------------------------------------------------------------
  logic                      in_fire;
  op_t                       op_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_BITS-1:0]     pen_r;
  logic [AW-1:0]             rd_addr_r;
  logic                      rd_ok_r;
  logic [RD_IDX_W-1:0]       in_rcol, in_rrow;

  assign in_fire = in_tvalid && in_tready;
  assign in_rcol = in_tdata[IN_RCOL_LSB +: RD_IDX_W];
  assign in_rrow = in_tdata[IN_RROW_LSB +: RD_IDX_W];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= op_t'(in_tuser[0]);
      sx_r      <= in_tdata[IN_SX_LSB +: COORD_W];
      sy_r      <= in_tdata[IN_SY_LSB +: COORD_W];
      ex_r      <= in_tdata[IN_EX_LSB +: COORD_W];
      ey_r      <= in_tdata[IN_EY_LSB +: COORD_W];
      // pen color masked / zero-extended to the stored pixel depth
      pen_r     <= COLOR_BITS'(in_tdata[IN_PEN_LSB +: PEN_W]);
      // read address: row * width + column, valid only when both are in range
      rd_addr_r <= AW'(AW'(in_rrow) * W_A) + AW'(in_rcol);
      rd_ok_r   <= (CMP_W'(in_rcol) < W_C) && (CMP_W'(in_rrow) < H_C);
    end
  end

  // ---------------------------------------------------------------------
  // Line walker and clip
  // ---------------------------------------------------------------------
  state_t  state_r, state_nxt;
  logic    walk_start;
  pixel_t  pix;
  logic    pix_hit;
  logic [AW-1:0] pix_addr;

  mlr_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .sx    (sx_r),
    .sy    (sy_r),
    .ex    (ex_r),
    .ey    (ey_r),
    .pix   (pix)
  );

  mlr_clip #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .AW           (AW)
  ) u_clip (
    .pix        (pix),
    .view_x_min (view_x_min_r),
    .view_y_min (view_y_min_r),
    .hit        (pix_hit),
    .addr       (pix_addr)
  );

  // ---------------------------------------------------------------------
  // Frame store; write port shared by the clearing pass and the walker
  // ---------------------------------------------------------------------
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COLOR_BITS-1:0] mem_wdata;
  logic [COLOR_BITS-1:0] mem_rdata;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;

  mlr_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COLOR_BITS)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [RES_COL_W-1:0] color_r, color_nxt;
  logic                 out_load;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    count_nxt    = count_r;
    color_nxt    = color_r;
    in_tready    = 1'b0;
    walk_start   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pix_addr;
    mem_wdata    = pen_r;
    out_load     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          count_nxt = '0;
          color_nxt = '0;
          state_nxt = (op_t'(in_tuser[0]) == OP_READ) ? ST_RD_ADDR : ST_DRAW_START;
        end
      end
      ST_DRAW_START: begin
        walk_start = 1'b1;
        state_nxt  = ST_DRAW;
      end
      ST_DRAW: begin
        mem_we = pix_hit;
        if (pix_hit) begin
          count_nxt = count_r + 1'b1;
        end
        if (pix.valid && pix.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RD_ADDR: begin
        // read address is presented; data registered at this edge
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        color_nxt = rd_ok_r ? RES_COL_W'(mem_rdata) : '0;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    color_r <= color_nxt;
  end

  // ---------------------------------------------------------------------
  // Output register: holds the result until the sink takes it
  // ---------------------------------------------------------------------
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = '0;
      if (op_r == OP_READ) begin
        out_tdata_nxt[OUT_COL_LSB +: RES_COL_W] = color_r;
      end else begin
        out_tdata_nxt[OUT_CNT_LSB +: COUNT_W] = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- sv/mlr_checker.sv -----
// Port-level checker for the midpoint line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mlr_checker
  import mlr_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // no transaction is accepted and no result presented while reset is held or as the clearing pass starts
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("accepting or presenting during reset clear");

  // one transaction in flight: ready drops right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while one is in flight");

  // a result carries either a color or a pixel count, never both
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_COL_LSB +: RES_COL_W] == '0)
                || (out_tdata[OUT_CNT_LSB +: COUNT_W] == '0))
    else $error("result has both color and count");

  // a line covers at most 4096 pixels
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_CNT_LSB +: COUNT_W] <= COUNT_W'(4096))
    else $error("pixel count out of range");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- bench/midpoint_line_rasterizer_test.sv -----
// Self-checking stream testbench for the midpoint line rasterizer.
`timescale 1ns / 1ps

module midpoint_line_rasterizer_test
  import mlr_pkg::*;
();

  // Frame geometry as signed ints so viewport math stays signed
  localparam int FRAME_W = FRAME_WIDTH_DEF;
  localparam int FRAME_H = FRAME_HEIGHT_DEF;

  localparam int PHASE_ITEMS   = 225;      // random transactions per viewport setting
  localparam int SETTLE_CYCLES = 8;        // quiet time before a config write / the end
  localparam int HOLD_AT       = 300;      // result count that starts the long back-pressure
  localparam int HOLD_LEN      = 600;      // cycles of out_tready held low
  localparam int QUIET_LO      = 500;      // transaction window with no idling on either side
  localparam int QUIET_HI      = 700;
  localparam int IDLE_PCT      = 27;
  // Watchdog limit: the clear pass plus the worst case for this stimulus, with margin
  localparam int CYCLE_LIMIT   = 3_000_000;

  // One input transaction, unpacked into its fields
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [PEN_W-1:0]          pen;
    logic [RD_IDX_W-1:0]       rcol;
    logic [RD_IDX_W-1:0]       rrow;
  } raster_job_t;

  // One predicted result transaction
  typedef struct packed {
    logic [RES_COL_W-1:0] color;
    logic [COUNT_W-1:0]   count;
  } raster_reply_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [0:0]             in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Testbench copy of the block's state
  logic [PEN_W-1:0]          frame_model [0:FRAME_W*FRAME_H-1];
  logic signed [COORD_W-1:0] view_x_min_m = '0;
  logic signed [COORD_W-1:0] view_y_min_m = '0;

  raster_job_t   draw_jobs[$];        // transactions not yet offered
  raster_reply_t raster_replies[$];   // predicted results, oldest first
  raster_job_t   offered_job;         // transaction currently on the input bus

  int items_offered  = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  bit hold_started   = 1'b0;

  always #10 clk = ~clk;

  midpoint_line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Store one pixel if it lands in the half-open viewport; rows are flipped.
  function automatic int plot_pixel(int x, int y, logic [PEN_W-1:0] color);
    int col, rel;
    col = x - view_x_min_m;
    rel = y - view_y_min_m;
    if (col < 0 || col >= FRAME_W || rel < 0 || rel >= FRAME_H) return 0;
    frame_model[(FRAME_H - 1 - rel) * FRAME_W + col] = color;
    return 1;
  endfunction

  // Integer midpoint walk; returns how many pixels fell inside the viewport.
  function automatic int rasterize(int x0, int y0, int x1, int y1, logic [PEN_W-1:0] color);
    int dx, dy, adx, ady, slope_sign, x, y, err, n, i, lo, hi;
    n  = 0;
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    slope_sign = ((dx < 0) != (dy < 0)) ? -1 : 1;
    if (dx == 0) begin
      // vertical, and the single-pixel case: bottom to top
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      for (y = lo; y <= hi; y++) n += plot_pixel(x0, y, color);
      return n;
    end
    if (dy == 0) slope_sign = 1;
    if (ady <= adx) begin
      // shallow: march in x from the left end, tie on err == 0 steps y
      if (dx < 0) begin
        x = x1; y = y1;
      end else begin
        x = x0; y = y0;
      end
      err = 2 * ady - adx;
      for (i = 0; i <= adx; i++) begin
        n += plot_pixel(x, y, color);
        if (err >= 0) begin
          y += slope_sign;
          err -= 2 * adx;
        end
        x++;
        err += 2 * ady;
      end
    end else begin
      // steep: march in y from the bottom end
      if (dy < 0) begin
        x = x1; y = y1;
      end else begin
        x = x0; y = y0;
      end
      err = 2 * adx - ady;
      for (i = 0; i <= ady; i++) begin
        n += plot_pixel(x, y, color);
        if (err >= 0) begin
          x += slope_sign;
          err -= 2 * ady;
        end
        y++;
        err += 2 * adx;
      end
    end
    return n;
  endfunction

  // Result of one accepted transaction; updates the frame copy for draws.
  function automatic raster_reply_t raster_step(raster_job_t j);
    raster_reply_t r;
    int n;
    r = '0;
    if (j.op == OP_DRAW) begin
      n = rasterize(j.sx, j.sy, j.ex, j.ey, j.pen);
      r.count = n[COUNT_W-1:0];
    end else begin
      r.color = frame_model[int'(j.rrow) * FRAME_W + int'(j.rcol)];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int full_coord();
    int u;
    u = $urandom_range(4095);
    return u - 2048;
  endfunction

  // Coordinate around the viewport, a little outside on both sides
  function automatic int coord_near(int lo);
    int off, v;
    off = $urandom_range(207);
    v = lo - 40 + off;
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  // Unused fields carry random junk; the block must ignore them
  function automatic raster_job_t draw_job(int sx, int sy, int ex, int ey, int pen);
    raster_job_t j;
    j.op   = OP_DRAW;
    j.sx   = sx[COORD_W-1:0];
    j.sy   = sy[COORD_W-1:0];
    j.ex   = ex[COORD_W-1:0];
    j.ey   = ey[COORD_W-1:0];
    j.pen  = pen[PEN_W-1:0];
    j.rcol = RD_IDX_W'($urandom_range(127));
    j.rrow = RD_IDX_W'($urandom_range(127));
    return j;
  endfunction

  function automatic raster_job_t read_job(int col, int row);
    raster_job_t j;
    j = draw_job(full_coord(), full_coord(), full_coord(), full_coord(), $urandom_range(255));
    j.op   = OP_READ;
    j.rcol = col[RD_IDX_W-1:0];
    j.rrow = row[RD_IDX_W-1:0];
    return j;
  endfunction

  // Read back the store location of device pixel (x,y), or a random one if off-screen
  function automatic raster_job_t read_at(int x, int y);
    int col, rel;
    col = x - view_x_min_m;
    rel = y - view_y_min_m;
    if (col < 0 || col >= FRAME_W || rel < 0 || rel >= FRAME_H)
      return read_job($urandom_range(127), $urandom_range(127));
    return read_job(col, FRAME_H - 1 - rel);
  endfunction

  // Random phase: mostly a draw followed by reads of its end pixels
  task automatic fill_phase(int n_items);
    int made, r, k, nreads, lo_x, lo_y;
    raster_job_t j;
    made = 0;
    lo_x = view_x_min_m;
    lo_y = view_y_min_m;
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        j = draw_job(coord_near(lo_x), coord_near(lo_y), coord_near(lo_x), coord_near(lo_y),
                     $urandom_range(255));
        draw_jobs.push_back(j);
        nreads = $urandom_range(1, 3);
        for (k = 0; k < nreads; k++) begin
          if (k[0] == 1'b0) draw_jobs.push_back(read_at(j.sx, j.sy));
          else draw_jobs.push_back(read_at(j.ex, j.ey));
        end
        made += 1 + nreads;
      end else if (r < 85) begin
        draw_jobs.push_back(read_job($urandom_range(127), $urandom_range(127)));
        made++;
      end else if (r < 95) begin
        draw_jobs.push_back(draw_job(coord_near(lo_x), coord_near(lo_y), coord_near(lo_x),
                                     coord_near(lo_y), $urandom_range(255)));
        made++;
      end else begin
        // long line from anywhere in the coordinate space to near the viewport
        draw_jobs.push_back(draw_job(full_coord(), full_coord(), coord_near(lo_x),
                                     coord_near(lo_y), $urandom_range(255)));
        made++;
      end
    end
  endtask

  // Both viewport registers, one write per cycle, only while the block is idle
  task automatic write_view(int x, int y);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VIEW_X_MIN;
    cfg_wdata <= x[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_VIEW_Y_MIN;
    cfg_wdata <= y[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    view_x_min_m = x[COORD_W-1:0];
    view_y_min_m = y[COORD_W-1:0];
  endtask

  // Wait until every queued transaction is taken and every result checked
  task automatic settle();
    while (draw_jobs.size() != 0 || items_offered != items_accepted ||
           raster_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers at the falling edge, holds the transaction until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : send_proc
    int gap;
    gap = (items_offered >= QUIET_LO && items_offered < QUIET_HI) ? 0 : IDLE_PCT;
    if (rst_n && items_offered == items_accepted) begin
      if (draw_jobs.size() != 0 && $urandom_range(99) >= gap) begin
        offered_job = draw_jobs.pop_front();
        items_offered++;
        in_tvalid <= 1'b1;
        in_tuser  <= offered_job.op;
        in_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, offered_job.rrow, offered_job.rcol,
                      offered_job.pen, offered_job.ey, offered_job.ex, offered_job.sy,
                      offered_job.sx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off that backs up the input
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sink_proc
    int stall;
    stall = (results_seen >= QUIET_LO && results_seen < QUIET_HI) ? 0 : IDLE_PCT;
    if (!hold_started && results_seen == HOLD_AT) begin
      hold_left    = HOLD_LEN;
      hold_started = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input acceptance, compare on output acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    raster_reply_t want;
    logic [RES_COL_W-1:0] got_color;
    logic [COUNT_W-1:0]   got_count;
    if (rst_n && in_tvalid && in_tready) begin
      raster_replies.push_back(raster_step(offered_job));
      items_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_color = out_tdata[OUT_COL_LSB +: RES_COL_W];
      got_count = out_tdata[OUT_CNT_LSB +: COUNT_W];
      results_seen++;
      if (raster_replies.size() == 0) begin
        $display("%0t: result with none pending: read_color %0d pixels_written %0d",
                 $time, got_color, got_count);
        error_count++;
      end else begin
        want = raster_replies.pop_front();
        if (got_color !== want.color) begin
          $display("%0t: read_color expected %0d actual %0d", $time, want.color, got_color);
          error_count++;
        end
        if (got_count !== want.count) begin
          $display("%0t: pixels_written expected %0d actual %0d", $time, want.count,
                   got_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("midpoint_line_rasterizer_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p, vx, vy;
    foreach (frame_model[i]) frame_model[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset viewport (0,0); queued during the clear pass,
    // so the first offer also checks that input stays stalled meanwhile.
    draw_jobs.push_back(read_job(0, 0));                              // cleared store
    draw_jobs.push_back(draw_job(0, 5, 127, 5, 8'hFF));               // horizontal
    draw_jobs.push_back(draw_job(20, 140, 20, -5, 8'h01));            // vertical, clipped both ends
    draw_jobs.push_back(draw_job(64, 64, 64, 64, 8'hAA));             // single point
    draw_jobs.push_back(draw_job(0, 0, 127, 127, 8'h55));             // 45 degrees, minor step at every pixel
    draw_jobs.push_back(draw_job(127, 0, 0, 127, 8'h33));             // falling diagonal
    draw_jobs.push_back(draw_job(30, 100, 40, 10, 8'h7E));            // steep, dy < 0
    draw_jobs.push_back(draw_job(120, 30, 5, 50, 8'h81));             // shallow, dx < 0
    draw_jobs.push_back(draw_job(10, 20, 13, 60, 8'hC3));             // steep, rising
    draw_jobs.push_back(draw_job(-2048, -2048, 2047, 2047, 8'h0F));   // corner to corner
    draw_jobs.push_back(draw_job(-2048, 2047, 2047, -2048, 8'hF0));
    draw_jobs.push_back(draw_job(2047, 100, -2048, 100, 8'h5A));      // full width, right to left
    draw_jobs.push_back(draw_job(50, -2048, 50, 2047, 8'hA5));        // full height
    draw_jobs.push_back(draw_job(-100, -100, -50, -10, 8'h77));       // fully outside
    draw_jobs.push_back(draw_job(70, 70, 71, 71, 8'h00));             // pen zero
    draw_jobs.push_back(draw_job(200, 0, 0, 1, 8'h3C));               // shallow, x falls as y rises
    draw_jobs.push_back(read_job(0, FRAME_H - 1));                    // pixel (0,0)
    draw_jobs.push_back(read_job(FRAME_W - 1, FRAME_H - 1));          // pixel (127,0)
    draw_jobs.push_back(read_job(FRAME_W - 1, 0));                    // pixel (127,127)
    draw_jobs.push_back(read_job(0, 0));                              // pixel (0,127)
    draw_jobs.push_back(read_job(64, 63));                            // the single point
    draw_jobs.push_back(read_job(20, 60));
    draw_jobs.push_back(read_job(50, 27));
    draw_jobs.push_back(read_job(5, 122));
    draw_jobs.push_back(read_job(71, 56));
    settle();

    // Random phases, one viewport setting each, extremes included
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin vx = -40;   vy = 25;    end
        1: begin vx = -2048; vy = -2048; end
        2: begin vx = 2047;  vy = 2047;  end
        3: begin vx = full_coord(); vy = full_coord(); end
        4: begin vx = -2048; vy = 2047;  end
        default: begin vx = 0; vy = 0; end
      endcase
      write_view(vx, vy);
      fill_phase(PHASE_ITEMS);
      settle();
    end

    if (error_count == 0) begin
      $display("midpoint_line_rasterizer_test: clean");
    end else begin
      $display("midpoint_line_rasterizer_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mlr_pkg.sv
sv/mlr_frame_mem.sv
sv/mlr_walker.sv
sv/mlr_clip.sv
sv/midpoint_line_rasterizer.sv
sv/mlr_checker.sv
bench/midpoint_line_rasterizer_test.sv
